>>> hdl/gpl_pkg.sv
// ----------------------------------------------------------------------------
// gpl_pkg
// shared types and constants of the gpio port with configuration lock
// ----------------------------------------------------------------------------
package gpl_pkg;

  localparam int PORT_W = 16;
  localparam int WORD_W = 32;

  // register select codes
  localparam logic [2:0] SEL_CFG_LOW  = 3'd0;
  localparam logic [2:0] SEL_CFG_HIGH = 3'd1;
  localparam logic [2:0] SEL_INPUT    = 3'd2;
  localparam logic [2:0] SEL_OUTPUT   = 3'd3;
  localparam logic [2:0] SEL_SET_RST  = 3'd4;
  localparam logic [2:0] SEL_RESET    = 3'd5;
  localparam logic [2:0] SEL_LOCK     = 3'd6;
  localparam logic [2:0] SEL_UNUSED   = 3'd7;

  // access kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // lock key sequence steps
  localparam logic [1:0] KEY_IDLE  = 2'd0;
  localparam logic [1:0] KEY_ONE   = 2'd1;
  localparam logic [1:0] KEY_TWO   = 2'd2;
  localparam logic [1:0] KEY_THREE = 2'd3;

  localparam logic [WORD_W-1:0] CFG_RESET = 32'h4444_4444;
  localparam int                KEY_BIT   = 16;
  localparam logic [3:0]        NIBBLE    = 4'hf;

  typedef struct packed {
    logic [WORD_W-1:0] cfg_low;
    logic [WORD_W-1:0] cfg_high;
    logic [PORT_W-1:0] out_data;
    logic [PORT_W-1:0] lock_bits;
    logic              lock_key;
    logic [1:0]        key_step;
  } gpl_state_t;

endpackage

>>> hdl/gpl_update.sv
// ----------------------------------------------------------------------------
// gpl_update
// next register state and read word for one bus access
// ----------------------------------------------------------------------------
module gpl_update #(
  parameter int PIN_COUNT = 16
) (
  input  gpl_pkg::gpl_state_t               state,
  input  logic                              cmd,
  input  logic [2:0]                        reg_select,
  input  logic [gpl_pkg::WORD_W-1:0]        write_data,
  input  logic [gpl_pkg::PORT_W-1:0]        pin_levels,
  output gpl_pkg::gpl_state_t               state_next,
  output logic [gpl_pkg::WORD_W-1:0]        read_data
);
  import gpl_pkg::*;

  localparam logic [PORT_W-1:0] PIN_MASK =
    PORT_W'((17'(1) << PIN_COUNT) - 17'(1));

  logic [PORT_W-1:0] lo;
  logic [PORT_W-1:0] hi;
  logic              key1;
  logic              same;
  logic [WORD_W-1:0] mask_low;
  logic [WORD_W-1:0] mask_high;

  assign lo   = write_data[PORT_W-1:0] & PIN_MASK;
  assign hi   = write_data[WORD_W-1:PORT_W] & PIN_MASK;
  assign key1 = write_data[KEY_BIT];
  assign same = (lo == state.lock_bits);

  // nibbles a cfg write may change: present and not locked
  always_comb begin
    mask_low  = '0;
    mask_high = '0;
    for (int i = 0; i < 8; i++) begin
      if ((i < PIN_COUNT) && !(state.lock_key && state.lock_bits[i])) begin
        mask_low[4*i +: 4] = NIBBLE;
      end
      if ((i + 8 < PIN_COUNT) && !(state.lock_key && state.lock_bits[i+8])) begin
        mask_high[4*i +: 4] = NIBBLE;
      end
    end
  end

  always_comb begin
    state_next = state;
    read_data  = '0;
    if (cmd == CMD_READ) begin
      unique case (reg_select)
        SEL_CFG_LOW:  read_data = state.cfg_low;
        SEL_CFG_HIGH: read_data = state.cfg_high;
        SEL_INPUT:    read_data = {{(WORD_W-PORT_W){1'b0}}, pin_levels & PIN_MASK};
        SEL_OUTPUT:   read_data = {{(WORD_W-PORT_W){1'b0}}, state.out_data};
        SEL_LOCK: begin
          read_data = {{(WORD_W-PORT_W-1){1'b0}}, state.lock_key, state.lock_bits};
          if (!state.lock_key) begin
            if (state.key_step == KEY_THREE) begin
              state_next.lock_key = 1'b1;
            end
            state_next.key_step = KEY_IDLE;
          end
        end
        default: read_data = '0;
      endcase
    end else begin
      unique case (reg_select)
        SEL_CFG_LOW:
          state_next.cfg_low = (state.cfg_low & ~mask_low) | (write_data & mask_low);
        SEL_CFG_HIGH:
          state_next.cfg_high = (state.cfg_high & ~mask_high) | (write_data & mask_high);
        SEL_OUTPUT:  state_next.out_data = lo;
        SEL_SET_RST: state_next.out_data = ((state.out_data & ~hi) | lo) & PIN_MASK;
        SEL_RESET:   state_next.out_data = state.out_data & ~lo & PIN_MASK;
        SEL_LOCK: begin
          if (!state.lock_key) begin
            priority if (state.key_step == KEY_IDLE && key1) begin
              state_next.key_step = KEY_ONE;
            end else if (state.key_step == KEY_ONE && !key1 && same) begin
              state_next.key_step = KEY_TWO;
            end else if (state.key_step == KEY_TWO && key1 && same) begin
              state_next.key_step = KEY_THREE;
            end else begin
              state_next.key_step = KEY_IDLE;
            end
            state_next.lock_bits = lo;
          end
        end
        default: state_next = state;
      endcase
    end
  end

endmodule

>>> hdl/gpio_port_with_config_lock.sv
// ----------------------------------------------------------------------------
// gpio_port_with_config_lock
// sixteen-pin gpio register block with a lock key on the pad configuration
// ----------------------------------------------------------------------------
// usage:
//   the slave stream carries one bus access per word: tuser holds the access
//   kind and the register select, tdata the write word and the sampled pin
//   levels. the master stream returns one word per access with the read
//   value and the port state after the access (output levels, both config
//   words, lock flag).
//   an accepted word shows on the master side in the cycle after its
//   acceptance. throughput is one access per cycle while the receiver
//   takes each result, set by the single result register; the register
//   state updates at acceptance. when the receiver stalls, the result
//   register holds its word and s_tready follows m_tready, so a new access
//   enters in the same cycle the waiting result leaves.
//   reset (rst, synchronous) returns both config words to 0x44444444,
//   clears output data, lock bits, lock flag and the key sequence, and
//   empties the result register.
// ----------------------------------------------------------------------------
module gpio_port_with_config_lock #(
  parameter int PIN_COUNT = 16
) (
  input  logic         clk,
  input  logic         rst,
  // slave side: accesses
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // write_data[31:0], pin_levels[47:32]
  input  logic [3:0]   s_tuser,   // cmd[0], reg_select[3:1]
  // master side: results
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata    // read_data[31:0], output_levels[47:32],
                                  // pad_config_low[79:48],
                                  // pad_config_high[111:80],
                                  // lock_active[112], zero pad[119:113]
);
  import gpl_pkg::*;

  gpl_state_t        state;
  gpl_state_t        state_next;
  logic [WORD_W-1:0] read_data;
  logic              accept;

  // result register
  logic              res_valid;
  logic [WORD_W-1:0] res_read;
  gpl_state_t        res_state;

  // output register empties as it is taken, so the pipe never bubbles
  assign s_tready = !res_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  gpl_update #(
    .PIN_COUNT(PIN_COUNT)
  ) u_update (
    .state      (state),
    .cmd        (s_tuser[0]),
    .reg_select (s_tuser[3:1]),
    .write_data (s_tdata[31:0]),
    .pin_levels (s_tdata[47:32]),
    .state_next (state_next),
    .read_data  (read_data)
  );

  // port registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state.cfg_low   <= CFG_RESET;
      state.cfg_high  <= CFG_RESET;
      state.out_data  <= '0;
      state.lock_bits <= '0;
      state.lock_key  <= 1'b0;
      state.key_step  <= KEY_IDLE;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s_tready) begin
      res_valid <= s_tvalid;
    end
  end

  // result payload, reports the state after the access
  always_ff @(posedge clk) begin
    if (accept) begin
      res_read  <= read_data;
      res_state <= state_next;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {7'b0, res_state.lock_key, res_state.cfg_high,
                     res_state.cfg_low, res_state.out_data, res_read};

endmodule

>>> hdl/gpl_checker.sv
// ----------------------------------------------------------------------------
// gpl_checker
// port-level checks of the gpio port with configuration lock
// ----------------------------------------------------------------------------
module gpl_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [3:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [119:0] m_tdata
);
  import gpl_pkg::*;

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a held result keeps its word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // an empty result register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked while output empty");

  // every write access returns a zero read word next cycle
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[0] == CMD_WRITE |=> m_tvalid && m_tdata[31:0] == '0)
    else $error("write access returned nonzero read word");

  // lock flag stays set once reported
  a_lock_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tdata[112] |=> !m_tvalid || m_tdata[112])
    else $error("lock flag dropped without reset");

endmodule

bind gpio_port_with_config_lock gpl_checker u_gpl_checker (.*);

>>> tb/gpio_port_with_config_lock_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_port_with_config_lock_test
// self-checking stream testbench for the gpio port with configuration lock
// ----------------------------------------------------------------------------
// a queue of bus accesses (directed corner cases, then random traffic built
// around lock key sequences) feeds a clocked driver. every accepted access
// runs through a local model of the port, which queues the expected result
// word. a clocked monitor compares each returned word field by field. both
// sides idle at random, the receiver holds off once for a long stretch and
// the sender pauses at marked words until all results are back.
// ----------------------------------------------------------------------------
module gpio_port_with_config_lock_test;
  import gpl_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving
  localparam int LONG_HOLD      = 200;   // receiver hold-off length
  localparam int HOLD_AT        = 500;   // results seen before the hold-off
  localparam int PHASE_A_END    = 840;   // accesses queued before the lock
  localparam int TOTAL_ACCESSES = 1450;

  // one bus access as queued for the driver
  typedef struct {
    logic              cmd;
    logic [2:0]        sel;
    logic [WORD_W-1:0] wdata;
    logic [PORT_W-1:0] pins;
    bit                drain;  // hold this word back until all results are in
  } bus_access_t;

  // port state reported with every result word
  typedef struct {
    logic [WORD_W-1:0] read_data;
    logic [PORT_W-1:0] output_levels;
    logic [WORD_W-1:0] pad_config_low;
    logic [WORD_W-1:0] pad_config_high;
    logic              lock_active;
  } port_snapshot_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [47:0]  s_tdata = '0;   // write_data[31:0], pin_levels[47:32]
  logic [3:0]   s_tuser = '0;   // cmd[0], reg_select[3:1]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [119:0] m_tdata;        // read_data, output_levels, pad_config_low,
                                // pad_config_high, lock_active, zero pad

  gpio_port_with_config_lock dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bus_access_t    pending_accesses[$];
  port_snapshot_t expected_snapshots[$];
  bus_access_t    on_bus;             // word currently offered to the port
  bit             drain_next = 1'b0;  // marks the next queued access

  int n_accepted = 0;   // accesses taken by the port
  int n_results  = 0;   // result words checked, updated at the edge
  int mismatches = 0;
  int cycle_no   = 0;
  bit held_off   = 1'b0;

  // local copy of the port registers
  logic [WORD_W-1:0] cfg_low_q   = CFG_RESET;
  logic [WORD_W-1:0] cfg_high_q  = CFG_RESET;
  logic [PORT_W-1:0] out_q       = '0;
  logic [PORT_W-1:0] lock_bits_q = '0;
  logic              lock_key_q  = 1'b0;
  logic [1:0]        key_step_q  = KEY_IDLE;

  // ---------------------------------------------------------------------------
  // port model
  // ---------------------------------------------------------------------------

  // nibbles of pins base..base+7 that a config write may still change
  function automatic logic [WORD_W-1:0] writable_nibbles(int base);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++)
      if (!(lock_key_q && lock_bits_q[base + i])) m[4*i +: 4] = NIBBLE;
    return m;
  endfunction

  function automatic port_snapshot_t apply_access(bus_access_t a);
    port_snapshot_t    r;
    logic [PORT_W-1:0] lo, hi;
    logic [WORD_W-1:0] m;
    logic              key_one, same_bits;
    r.read_data = '0;
    lo = a.wdata[PORT_W-1:0];
    hi = a.wdata[WORD_W-1:PORT_W];
    if (a.cmd == CMD_READ) begin
      case (a.sel)
        SEL_CFG_LOW:  r.read_data = cfg_low_q;
        SEL_CFG_HIGH: r.read_data = cfg_high_q;
        SEL_INPUT:    r.read_data = {16'h0, a.pins};
        SEL_OUTPUT:   r.read_data = {16'h0, out_q};
        SEL_LOCK: begin
          // old value first, then the last key step takes effect
          r.read_data = {15'h0, lock_key_q, lock_bits_q};
          if (!lock_key_q) begin
            if (key_step_q == KEY_THREE) lock_key_q = 1'b1;
            key_step_q = KEY_IDLE;
          end
        end
        default: ;
      endcase
    end else begin
      case (a.sel)
        SEL_CFG_LOW: begin
          m = writable_nibbles(0);
          cfg_low_q = (cfg_low_q & ~m) | (a.wdata & m);
        end
        SEL_CFG_HIGH: begin
          m = writable_nibbles(8);
          cfg_high_q = (cfg_high_q & ~m) | (a.wdata & m);
        end
        SEL_OUTPUT:  out_q = lo;
        SEL_SET_RST: out_q = (out_q & ~hi) | lo;  // set wins
        SEL_RESET:   out_q = out_q & ~lo;
        SEL_LOCK: begin
          if (!lock_key_q) begin
            key_one   = a.wdata[KEY_BIT];
            same_bits = (lo == lock_bits_q);
            if (key_step_q == KEY_IDLE && key_one)
              key_step_q = KEY_ONE;
            else if (key_step_q == KEY_ONE && !key_one && same_bits)
              key_step_q = KEY_TWO;
            else if (key_step_q == KEY_TWO && key_one && same_bits)
              key_step_q = KEY_THREE;
            else
              key_step_q = KEY_IDLE;
            lock_bits_q = lo;
          end
        end
        default: ;  // input data and unused select ignore writes
      endcase
    end
    r.output_levels   = out_q;
    r.pad_config_low  = cfg_low_q;
    r.pad_config_high = cfg_high_q;
    r.lock_active     = lock_key_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------

  function automatic void queue_access(logic cmd, logic [2:0] sel,
                                       logic [WORD_W-1:0] wdata,
                                       logic [PORT_W-1:0] pins);
    bus_access_t a;
    a.cmd   = cmd;
    a.sel   = sel;
    a.wdata = wdata;
    a.pins  = pins;
    a.drain = drain_next;
    drain_next = 1'b0;
    pending_accesses.push_back(a);
  endfunction

  // any access that leaves the key sequence alone
  function automatic void filler_access();
    logic [2:0] plain_sels[7];
    plain_sels = '{SEL_CFG_LOW, SEL_CFG_HIGH, SEL_INPUT, SEL_OUTPUT,
                   SEL_SET_RST, SEL_RESET, SEL_UNUSED};
    queue_access(logic'($urandom_range(0, 1)), plain_sels[$urandom_range(0, 6)],
                 $urandom, PORT_W'($urandom));
  endfunction

  // any access at all, lock register included
  function automatic void noise_access();
    queue_access(logic'($urandom_range(0, 1)),
                 3'($urandom_range(SEL_CFG_LOW, SEL_UNUSED)), $urandom,
                 PORT_W'($urandom));
  endfunction

  // write 1, write 0, write 1, read, with other registers mixed in between;
  // broken_step picks the step that goes wrong, 4 runs it through
  function automatic void key_attempt(logic [PORT_W-1:0] bits, int broken_step);
    logic [WORD_W-1:0] w;
    int                kind;
    for (int step = 0; step < 4; step++) begin
      if (step > 0) repeat ($urandom_range(0, 2)) filler_access();
      w = $urandom;
      w[PORT_W-1:0] = bits;
      w[KEY_BIT]    = (step != 1);
      if (step == broken_step) begin
        if (step == 3) begin
          // write where a read belongs
          queue_access(CMD_WRITE, SEL_LOCK, w, PORT_W'($urandom));
        end else begin
          kind = $urandom_range(0, 2);
          if (step == 0 && kind == 1) kind = 0;  // new bits are no fault at idle
          if (kind == 2) begin
            queue_access(CMD_READ, SEL_LOCK, $urandom, PORT_W'($urandom));
          end else begin
            if (kind == 0) w[KEY_BIT] = ~w[KEY_BIT];
            else w[PORT_W-1:0] = bits ^ PORT_W'($urandom_range(1, 65535));
            queue_access(CMD_WRITE, SEL_LOCK, w, PORT_W'($urandom));
          end
        end
        return;
      end
      if (step == 3) queue_access(CMD_READ, SEL_LOCK, $urandom, PORT_W'($urandom));
      else queue_access(CMD_WRITE, SEL_LOCK, w, PORT_W'($urandom));
    end
  endfunction

  // idle length: mostly none or short, now and then long, none in calm stretches
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // driver, receiver and monitor
  // ---------------------------------------------------------------------------

  always @(posedge clk) cycle_no <= cycle_no + 1;

  // sender: offer queued words, idle between them, drain where marked
  int tx_gap = 0;
  always @(posedge clk) begin
    logic offer;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      offer = s_tvalid;
      if (s_tvalid && s_tready) begin
        // word taken at this edge: model it now, in acceptance order
        expected_snapshots.push_back(apply_access(on_bus));
        n_accepted++;
        offer  = 1'b0;
        tx_gap = pick_gap(cycle_no[8:7] == 2'b01);
      end
      if (!offer) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_accesses.size() > 0 &&
                     (!pending_accesses[0].drain || n_results == n_accepted)) begin
          on_bus = pending_accesses.pop_front();
          offer  = 1'b1;
          s_tdata <= {on_bus.pins, on_bus.wdata};
          s_tuser <= {on_bus.sel, on_bus.cmd};
        end
      end
      s_tvalid <= offer;
    end
  end

  // receiver: random stalls plus one long hold-off while the sender keeps going
  int rx_gap  = 0;
  int rx_hold = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) rx_gap = pick_gap(cycle_no[8:7] == 2'b00);
      if (!held_off && n_results >= HOLD_AT) begin
        held_off = 1'b1;
        rx_hold  = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic void report_mismatch(string what, logic [WORD_W-1:0] want,
                                          logic [WORD_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at result word %0d: expected %h, got %h",
               what, n_results, want, got);
  endfunction

  // monitor: every result word against the oldest expectation
  always @(posedge clk) begin
    port_snapshot_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got.read_data       = m_tdata[31:0];
      got.output_levels   = m_tdata[47:32];
      got.pad_config_low  = m_tdata[79:48];
      got.pad_config_high = m_tdata[111:80];
      got.lock_active     = m_tdata[112];
      if (expected_snapshots.size() == 0) begin
        report_mismatch("unexpected result word", '0, got.read_data);
      end else begin
        want = expected_snapshots.pop_front();
        if (got.read_data !== want.read_data)
          report_mismatch("read_data", want.read_data, got.read_data);
        if (got.output_levels !== want.output_levels)
          report_mismatch("output_levels", 32'(want.output_levels),
                          32'(got.output_levels));
        if (got.pad_config_low !== want.pad_config_low)
          report_mismatch("pad_config_low", want.pad_config_low, got.pad_config_low);
        if (got.pad_config_high !== want.pad_config_high)
          report_mismatch("pad_config_high", want.pad_config_high,
                          got.pad_config_high);
        if (got.lock_active !== want.lock_active)
          report_mismatch("lock_active", 32'(want.lock_active), 32'(got.lock_active));
      end
      n_results <= n_results + 1;
    end
  end

  // watchdog: no word moving on either side for too long ends the run
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int r;

    // directed: reset values, pin extremes, every register and operation
    queue_access(CMD_READ,  SEL_CFG_LOW,  $urandom, PORT_W'($urandom));
    queue_access(CMD_READ,  SEL_CFG_HIGH, $urandom, PORT_W'($urandom));
    queue_access(CMD_READ,  SEL_INPUT,    $urandom, 16'hffff);
    queue_access(CMD_READ,  SEL_INPUT,    $urandom, 16'h0000);
    queue_access(CMD_WRITE, SEL_CFG_LOW,  32'hffff_ffff, PORT_W'($urandom));
    queue_access(CMD_WRITE, SEL_CFG_HIGH, 32'h0000_0000, PORT_W'($urandom));
    queue_access(CMD_READ,  SEL_CFG_LOW,  $urandom, PORT_W'($urandom));
    queue_access(CMD_READ,  SEL_CFG_HIGH, $urandom, PORT_W'($urandom));
    // upper half dropped
    queue_access(CMD_WRITE, SEL_OUTPUT,   32'hffff_ffff, PORT_W'($urandom));
    queue_access(CMD_READ,  SEL_OUTPUT,   $urandom, PORT_W'($urandom));
    // clear all, then set beats clear
    queue_access(CMD_WRITE, SEL_SET_RST,  32'hffff_0000, PORT_W'($urandom));
    queue_access(CMD_WRITE, SEL_SET_RST,  32'hffff_ffff, PORT_W'($urandom));
    queue_access(CMD_WRITE, SEL_RESET,    32'h0000_00ff, PORT_W'($urandom));
    // write-only registers
    queue_access(CMD_READ,  SEL_SET_RST,  $urandom, PORT_W'($urandom));
    queue_access(CMD_READ,  SEL_RESET,    $urandom, PORT_W'($urandom));
    // ignored writes
    queue_access(CMD_WRITE, SEL_INPUT,    32'hffff_ffff, PORT_W'($urandom));
    queue_access(CMD_WRITE, SEL_UNUSED,   32'hffff_ffff, PORT_W'($urandom));
    queue_access(CMD_READ,  SEL_UNUSED,   $urandom, PORT_W'($urandom));
    // wrong step at idle
    queue_access(CMD_READ,  SEL_LOCK,     $urandom, PORT_W'($urandom));
    // key sequence up to its last step, then a write instead of the read
    queue_access(CMD_WRITE, SEL_LOCK,     32'h0001_a5a5, PORT_W'($urandom));
    queue_access(CMD_WRITE, SEL_LOCK,     32'h0000_a5a5, PORT_W'($urandom));
    queue_access(CMD_WRITE, SEL_LOCK,     32'h0001_a5a5, PORT_W'($urandom));
    queue_access(CMD_WRITE, SEL_LOCK,     32'hffff_ffff, PORT_W'($urandom));
    queue_access(CMD_READ,  SEL_LOCK,     $urandom, PORT_W'($urandom));

    // before the lock: key sequences that go wrong at some step, plus noise
    while (pending_accesses.size() < PHASE_A_END) begin
      if (pending_accesses.size() > PHASE_A_END / 2 && !drain_next &&
          pending_accesses.size() < PHASE_A_END / 2 + 3)
        drain_next = 1'b1;  // mark a pause in the middle until all results are in
      r = $urandom_range(0, 99);
      if (r < 55) key_attempt(PORT_W'($urandom), $urandom_range(0, 3));
      else noise_access();
    end

    // sender pauses, then a clean key sequence engages the lock
    drain_next = 1'b1;
    key_attempt(PORT_W'($urandom), 4);

    // after the lock: config writes against frozen nibbles, ignored lock traffic
    while (pending_accesses.size() < TOTAL_ACCESSES) begin
      r = $urandom_range(0, 99);
      if (r < 40)
        queue_access(CMD_WRITE, ($urandom_range(0, 1) ? SEL_CFG_HIGH : SEL_CFG_LOW),
                     $urandom, PORT_W'($urandom));
      else if (r < 55) key_attempt(PORT_W'($urandom), $urandom_range(0, 4));
      else noise_access();
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // wait until every access is in and every result word is back
    do @(negedge clk);
    while (pending_accesses.size() != 0 || s_tvalid || expected_snapshots.size() != 0);
    repeat (5) @(posedge clk);  // margin before the final checks

    if (expected_snapshots.size() != 0) begin
      mismatches += expected_snapshots.size();
      $display("%0d expected result words never arrived", expected_snapshots.size());
    end

    $display("%0d accesses over all seven registers and the unused select, %0d words checked",
             n_accepted, n_results);
    $display("lock engaged: %0d, long receiver hold-off: %0d, mismatches: %0d",
             lock_key_q, held_off, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
